[hw/rtl/roi_qp_offset_map_defines.svh]
// assertion macros for the roi qp offset map
`ifndef ROI_QP_OFFSET_MAP_DEFINES_SVH
`define ROI_QP_OFFSET_MAP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RQM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rqm assertion failed");

// next-cycle implication, disabled in reset
`define RQM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rqm assertion failed");

`endif

[hw/rtl/rqm_pkg.sv]
// shared types and constants for the roi qp offset map
package rqm_pkg;
	localparam int MB_SIZE = 16;
	localparam int MAX_MB = 512;
	localparam int MBW = 10;     // macroblock count width
	localparam int RW = 19;      // roi macroblock count width
	localparam int MUL_AW = 22;
	localparam int MUL_BW = 17;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam logic [9:0] QP_MAX = 10'd816;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WH, ST_FR, ST_RND, ST_GCD, ST_GCDW, ST_DMW, ST_DMWW,
		ST_DMH, ST_DMHW, ST_LIM, ST_LIMR, ST_SQ, ST_SQM, ST_CMP, ST_DR,
		ST_DRW, ST_FIN
	} state_t;

	typedef struct packed {
		logic          start;
		logic [RW-1:0] dividend;
		logic [MBW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           busy;
		logic [RW-1:0]  quo;
		logic [MBW-1:0] rem;
	} div_rsp_t;
endpackage

[hw/rtl/rqm_if.sv]
// handshake interfaces for query, result and register channels
interface rqm_req_if;
	logic        valid;
	logic        ready;
	logic [16:0] roi_fraction;
	logic [9:0]  qp_delta;
	logic [8:0]  mb_row;
	logic [8:0]  mb_col;
	modport source (output valid, roi_fraction, qp_delta, mb_row, mb_col, input ready);
	modport sink (input valid, roi_fraction, qp_delta, mb_row, mb_col, output ready);
endinterface

interface rqm_rsp_if;
	logic       valid;
	logic       ready;
	logic [9:0] qp_offset;
	logic       in_roi;
	logic       position_valid;
	modport source (output valid, qp_offset, in_roi, position_valid, input ready);
	modport sink (input valid, qp_offset, in_roi, position_valid, output ready);
endinterface

interface rqm_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [13:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/rqm_mul.sv]
// shared multiplier with registered product
module rqm_mul (
	input  logic                       clk,
	input  logic [rqm_pkg::MUL_AW-1:0] a,
	input  logic [rqm_pkg::MUL_BW-1:0] b,
	output logic [rqm_pkg::MUL_PW-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= {{rqm_pkg::MUL_BW{1'b0}}, a} * {{rqm_pkg::MUL_AW{1'b0}}, b};
	end
endmodule

[hw/rtl/rqm_div.sv]
// restoring divider, one quotient bit per cycle
module rqm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rqm_pkg::div_req_t req,
	output rqm_pkg::div_rsp_t rsp
);
	localparam int RW = rqm_pkg::RW;
	localparam int DW = rqm_pkg::MBW;

	logic [4:0]    cnt_q;
	logic [RW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;

	assign shifted = {rem_q, quo_q[RW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 5'(RW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[RW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;
endmodule

[hw/rtl/roi_qp_offset_map.sv]
// roi qp offset map: one macroblock qp offset per query
//
// channels: req carries roi_fraction, qp_delta, mb_row and mb_col; rsp returns
// qp_offset, in_roi and position_valid; cfg writes frame_width (index 0) and
// frame_height (index 1), always ready, to be written only while idle
// one query is worked on at a time; req.ready is high only when the sequencer
// is idle, and a query transfer makes it busy until its result is loaded
// invalid positions, full and empty fractions go straight to the result;
// otherwise the query runs through the shared restoring divider (19 steps)
// in the euclid gcd loop, the two ratio divisions and the row division, plus
// a square, multiply and compare step per bit over 10 bits of the rounded
// square root, which runs on the shared multiplier
// the result sits in an output register; the next query is taken while it
// waits, and a stalled receiver holds only the final load of the next result
// reset: frame size returns to 1920 x 1080, no result pending, sequencer idle
`include "roi_qp_offset_map_defines.svh"

module roi_qp_offset_map (
	input  logic clk,
	input  logic arst_n,
	rqm_req_if.sink   req,
	rqm_rsp_if.source rsp,
	rqm_cfg_if.sink   cfg
);
	localparam int MBW = rqm_pkg::MBW;
	localparam int RW = rqm_pkg::RW;
	localparam int GW = 21;  // signed geometry width

	rqm_pkg::state_t st_q, st_d;

	logic [13:0] fw_q, fh_q;
	logic [16:0] frac_q;
	logic [9:0]  delta_q;
	logic [8:0]  row_q, col_q;
	logic        pos_ok_q, full_q, geom_ok_q;
	logic [MBW-1:0] a_q, b_q, g_q, mw_q, mh_q, n_q, last_q;
	logic [RW-1:0]  r_q, rows_q;
	logic [30:0]    lim_q;
	logic [3:0]     bit_q;

	logic [MBW-1:0] w_mb, h_mb;
	logic [14:0]    fw_sum, fh_sum;
	logic [10:0]    w_raw, h_raw;

	logic [rqm_pkg::MUL_AW-1:0] mul_a;
	logic [rqm_pkg::MUL_BW-1:0] mul_b;
	logic [rqm_pkg::MUL_PW-1:0] prod_q;
	rqm_pkg::div_req_t dreq;
	rqm_pkg::div_rsp_t drsp;

	logic [MBW-1:0] cand;
	logic [MBW:0]   odd;
	logic [35:0]    r_sum;
	logic           req_xfer, out_free, roi_hit, pos_in;
	logic signed [GW-1:0] top, left, di, dj, rows_s, rw_s, last_s;

	rqm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));
	rqm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// macroblock counts, clamped to the grid limits
	assign fw_sum = {1'b0, fw_q} + 15'(rqm_pkg::MB_SIZE - 1);
	assign fh_sum = {1'b0, fh_q} + 15'(rqm_pkg::MB_SIZE - 1);
	assign w_raw = fw_sum[14:4];
	assign h_raw = fh_sum[14:4];
	assign w_mb = (w_raw == '0) ? MBW'(1) :
		(w_raw > 11'(rqm_pkg::MAX_MB)) ? MBW'(rqm_pkg::MAX_MB) : w_raw[MBW-1:0];
	assign h_mb = (h_raw == '0) ? MBW'(1) :
		(h_raw > 11'(rqm_pkg::MAX_MB)) ? MBW'(rqm_pkg::MAX_MB) : h_raw[MBW-1:0];

	// position check at full count width, a 512 wide grid included
	assign pos_in = (MBW'(req.mb_row) < h_mb) && (MBW'(req.mb_col) < w_mb);

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (st_q == rqm_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp.valid || rsp.ready;

	// square root trial value and its odd term 2n-1
	assign cand = n_q | (MBW'(1) << bit_q);
	assign odd = {cand, 1'b0} - (MBW+1)'(1);
	assign r_sum = prod_q[35:0] + 36'd32768;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 14'd1920;
			fh_q <= 14'd1080;
		end else if (cfg.valid && cfg.ready) begin
			case (rqm_pkg::reg_idx_t'(cfg.index))
				rqm_pkg::REG_FRAME_WIDTH:  fw_q <= cfg.data;
				rqm_pkg::REG_FRAME_HEIGHT: fh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			rqm_pkg::ST_WH: begin
				mul_a = 22'(w_mb);
				mul_b = 17'(h_mb);
			end
			rqm_pkg::ST_FR: begin
				mul_a = 22'(prod_q[RW-1:0]);
				mul_b = frac_q;
			end
			rqm_pkg::ST_LIM: begin
				mul_a = 22'(r_q);
				mul_b = 17'(mw_q);
			end
			rqm_pkg::ST_SQ: begin
				mul_a = 22'(odd);
				mul_b = 17'(odd);
			end
			rqm_pkg::ST_SQM: begin
				mul_a = prod_q[21:0];
				mul_b = 17'(mh_q);
			end
			default: ;
		endcase
	end

	// divider requests
	always_comb begin
		dreq = '0;
		case (st_q)
			rqm_pkg::ST_GCD: begin
				dreq.start = (a_q != '0);
				dreq.dividend = RW'(b_q);
				dreq.divisor = a_q;
			end
			rqm_pkg::ST_DMW: begin
				dreq.start = 1'b1;
				dreq.dividend = RW'(w_mb);
				dreq.divisor = g_q;
			end
			rqm_pkg::ST_DMH: begin
				dreq.start = 1'b1;
				dreq.dividend = RW'(h_mb);
				dreq.divisor = g_q;
			end
			rqm_pkg::ST_DR: begin
				dreq.start = 1'b1;
				dreq.dividend = r_q;
				dreq.divisor = n_q;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			rqm_pkg::ST_IDLE: if (req_xfer) begin
				if (!pos_in || req.roi_fraction[16] || req.roi_fraction == '0) begin
					st_d = rqm_pkg::ST_FIN;
				end else begin
					st_d = rqm_pkg::ST_WH;
				end
			end
			rqm_pkg::ST_WH:   st_d = rqm_pkg::ST_FR;
			rqm_pkg::ST_FR:   st_d = rqm_pkg::ST_RND;
			rqm_pkg::ST_RND:  st_d = rqm_pkg::ST_GCD;
			rqm_pkg::ST_GCD:  st_d = (a_q == '0) ? rqm_pkg::ST_DMW : rqm_pkg::ST_GCDW;
			rqm_pkg::ST_GCDW: if (!drsp.busy) st_d = rqm_pkg::ST_GCD;
			rqm_pkg::ST_DMW:  st_d = rqm_pkg::ST_DMWW;
			rqm_pkg::ST_DMWW: if (!drsp.busy) st_d = rqm_pkg::ST_DMH;
			rqm_pkg::ST_DMH:  st_d = rqm_pkg::ST_DMHW;
			rqm_pkg::ST_DMHW: if (!drsp.busy) st_d = rqm_pkg::ST_LIM;
			rqm_pkg::ST_LIM:  st_d = rqm_pkg::ST_LIMR;
			rqm_pkg::ST_LIMR: st_d = rqm_pkg::ST_SQ;
			rqm_pkg::ST_SQ:   st_d = rqm_pkg::ST_SQM;
			rqm_pkg::ST_SQM:  st_d = rqm_pkg::ST_CMP;
			rqm_pkg::ST_CMP: begin
				if (bit_q != '0) begin
					st_d = rqm_pkg::ST_SQ;
				end else if (((prod_q <= 39'(lim_q)) ? cand : n_q) == '0) begin
					st_d = rqm_pkg::ST_FIN;
				end else begin
					st_d = rqm_pkg::ST_DR;
				end
			end
			rqm_pkg::ST_DR:   st_d = rqm_pkg::ST_DRW;
			rqm_pkg::ST_DRW:  if (!drsp.busy) st_d = rqm_pkg::ST_FIN;
			rqm_pkg::ST_FIN:  if (out_free) st_d = rqm_pkg::ST_IDLE;
			default:          st_d = rqm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rqm_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_ok_q <= 1'b0;
		end else if (req_xfer) begin
			geom_ok_q <= 1'b0;
		end else if (st_q == rqm_pkg::ST_DRW && !drsp.busy) begin
			geom_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			rqm_pkg::ST_IDLE: if (req_xfer) begin
				frac_q <= req.roi_fraction;
				delta_q <= (req.qp_delta > rqm_pkg::QP_MAX) ? rqm_pkg::QP_MAX : req.qp_delta;
				row_q <= req.mb_row;
				col_q <= req.mb_col;
				pos_ok_q <= pos_in;
				full_q <= req.roi_fraction[16];
				a_q <= w_mb;
				b_q <= h_mb;
				n_q <= '0;
			end
			rqm_pkg::ST_RND: r_q <= r_sum[RW+15:16];
			rqm_pkg::ST_GCD: if (a_q == '0) g_q <= b_q;
			rqm_pkg::ST_GCDW: if (!drsp.busy) begin
				a_q <= drsp.rem;
				b_q <= a_q;
			end
			rqm_pkg::ST_DMWW: if (!drsp.busy) mw_q <= drsp.quo[MBW-1:0];
			rqm_pkg::ST_DMHW: if (!drsp.busy) mh_q <= drsp.quo[MBW-1:0];
			rqm_pkg::ST_LIMR: begin
				lim_q <= {prod_q[28:0], 2'b00};
				bit_q <= 4'(MBW - 1);
			end
			rqm_pkg::ST_CMP: begin
				if (prod_q <= 39'(lim_q)) n_q <= cand;
				if (bit_q != '0) bit_q <= bit_q - 4'd1;
			end
			rqm_pkg::ST_DRW: if (!drsp.busy) begin
				rows_q <= drsp.quo + RW'(drsp.rem != '0);
				last_q <= drsp.rem;
			end
			default: ;
		endcase
	end

	// roi rectangle test with a signed corner, clipped to the grid
	always_comb begin
		rows_s = GW'(rows_q);
		rw_s = GW'(n_q);
		last_s = GW'(last_q);
		top = GW'(h_mb >> 1) - ((rows_s + GW'(1)) >>> 1);
		left = GW'(w_mb >> 1) - ((rw_s + GW'(1)) >>> 1);
		di = GW'(row_q) - top;
		dj = GW'(col_q) - left;
		roi_hit = full_q;
		if (!full_q && geom_ok_q && di >= 0 && di < rows_s && dj >= 0 && dj < rw_s) begin
			roi_hit = !(di == rows_s - GW'(1) && last_s != '0 && dj >= last_s);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (st_q == rqm_pkg::ST_FIN && out_free) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == rqm_pkg::ST_FIN && out_free) begin
			rsp.position_valid <= pos_ok_q;
			rsp.in_roi <= pos_ok_q && roi_hit;
			rsp.qp_offset <= (pos_ok_q && !roi_hit) ? delta_q : 10'd0;
		end
	end

	`RQM_ASSERT_NXT(a_one_query, clk, arst_n, req.valid && req.ready, !req.ready)
	`RQM_ASSERT_IMP(a_div_idle, clk, arst_n, st_q == rqm_pkg::ST_IDLE, !drsp.busy)
	`RQM_ASSERT_IMP(a_invalid_pos, clk, arst_n, rsp.valid && !rsp.position_valid,
		rsp.qp_offset == 10'd0 && !rsp.in_roi)
endmodule

[dv/rqm_tb_scoreboard.sv]
// scoreboard for the roi qp offset map: predicts and checks offsets
`timescale 1ns / 1ps

class rqm_offset_scoreboard;
	typedef struct packed {
		logic [9:0] qp_offset;
		logic       in_roi;
		logic       position_valid;
	} offset_t;

	offset_t     pending[$];
	logic [13:0] frame_w;
	logic [13:0] frame_h;
	int          mismatches;

	function new();
		frame_w = 14'd1920;
		frame_h = 14'd1080;
		mismatches = 0;
	endfunction

	function void write_reg(rqm_pkg::reg_idx_t idx, logic [13:0] value);
		if (idx == rqm_pkg::REG_FRAME_WIDTH)
			frame_w = value;
		else
			frame_h = value;
	endfunction

	function longint mbs(logic [13:0] px);
		longint n;
		n = (longint'(px) + 15) / 16;
		if (n < 1) n = 1;
		if (n > 512) n = 512;
		return n;
	endfunction

	function offset_t predict(logic [16:0] frac_in, logic [9:0] delta_in,
			logic [8:0] row, logic [8:0] col);
		offset_t o;
		longint w, h, a, b, t, mw, mh, r, rw, lim, cand, odd, rows, last, top, left, i, j;
		logic roi_hit;
		longint frac, delta;
		w = mbs(frame_w);
		h = mbs(frame_h);
		frac = frac_in;
		delta = delta_in;
		roi_hit = 0;
		if (delta > 816) delta = 816;
		if (frac > 65536) frac = 65536;
		if (row >= h || col >= w) begin
			o = '0;
			return o;
		end
		if (frac == 65536) begin
			roi_hit = 1;
		end else if (frac != 0) begin
			a = w;
			b = h;
			while (a != 0) begin
				t = a;
				a = b % a;
				b = t;
			end
			mw = w / b;
			mh = h / b;
			r = (frac * w * h + 32768) >>> 16;
			lim = 4 * r * mw;
			rw = 0;
			for (int k = 15; k >= 0; k--) begin
				cand = rw | (longint'(1) << k);
				odd = 2 * cand - 1;
				if (odd * odd * mh <= lim) rw = cand;
			end
			if (rw != 0) begin
				rows = (r + rw - 1) / rw;
				last = r % rw;
				top = h / 2 - (rows + 1) / 2;
				left = w / 2 - (rw + 1) / 2;
				i = longint'(row) - top;
				j = longint'(col) - left;
				if (i >= 0 && i < rows && j >= 0 && j < rw)
					roi_hit = !(i == rows - 1 && last != 0 && j >= last);
			end
		end
		o.qp_offset = roi_hit ? 10'd0 : delta[9:0];
		o.in_roi = roi_hit;
		o.position_valid = 1'b1;
		return o;
	endfunction

	function void note_query(logic [16:0] f, logic [9:0] d, logic [8:0] r, logic [8:0] c);
		pending.push_back(predict(f, d, r, c));
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		mismatches++;
	endtask

	task check_offset(logic [9:0] qp, logic roi, logic pv);
		offset_t e;
		if (pending.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = pending.pop_front();
		if (qp !== e.qp_offset)
			report($sformatf("qp_offset got %0d want %0d", qp, e.qp_offset));
		if (roi !== e.in_roi)
			report($sformatf("in_roi got %0b want %0b", roi, e.in_roi));
		if (pv !== e.position_valid)
			report($sformatf("position_valid got %0b want %0b", pv, e.position_valid));
	endtask
endclass

[dv/roi_qp_offset_map_tb.sv]
// testbench top for the roi qp offset map
`timescale 1ns / 1ps

module roi_qp_offset_map_tb;
	logic clk;
	logic arst_n;
	longint cycles;
	logic hold_off;   // long receiver stall, forces the block to back up
	logic stall_pat;  // ordinary receiver stall pattern

	rqm_req_if req();
	rqm_rsp_if rsp();
	rqm_cfg_if cfg();

	rqm_offset_scoreboard offsets;

	roi_qp_offset_map dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous limit: ~2000 queries plus stalls and gaps
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver: check every result transfer
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			offsets.check_offset(rsp.qp_offset, rsp.in_roi, rsp.position_valid);
	end

	// receiver stall pattern, with quiet stretches where it never stalls
	initial begin
		int mode;
		stall_pat = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				stall_pat <= (mode == 0) ? 1'b0 :
					(mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 0);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !stall_pat && !hold_off;
	end

	// one query transfer, held until accepted
	task automatic send_query(logic [16:0] f, logic [9:0] d, logic [8:0] r, logic [8:0] c);
		req.valid <= 1'b1;
		req.roi_fraction <= f;
		req.qp_delta <= d;
		req.mb_row <= r;
		req.mb_col <= c;
		do @(posedge clk); while (!req.ready);
		offsets.note_query(f, d, r, c);
	endtask

	task automatic idle_gap(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// register writes only while idle: drain and let the block settle
	task automatic drain();
		req.valid <= 1'b0;
		while (offsets.pending.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// one register transfer; the caller drops valid after the last one
	task automatic write_reg(rqm_pkg::reg_idx_t idx, logic [13:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		offsets.write_reg(idx, value);
	endtask

	task automatic set_frame(logic [13:0] w, logic [13:0] h);
		drain();
		write_reg(rqm_pkg::REG_FRAME_WIDTH, w);
		write_reg(rqm_pkg::REG_FRAME_HEIGHT, h);
		cfg.valid <= 1'b0;
	endtask

	// positions biased towards the grid, with some outside it
	task automatic random_query();
		int wmb, hmb;
		logic [16:0] f;
		logic [9:0] d;
		logic [8:0] r, c;
		wmb = int'(offsets.mbs(offsets.frame_w));
		hmb = int'(offsets.mbs(offsets.frame_h));
		case ($urandom_range(0, 9))
			0: f = 17'd0;
			1: f = 17'd65536;
			2: f = 17'($urandom_range(65537, 131071));
			default: f = 17'($urandom_range(1, 65535));
		endcase
		d = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(817, 1023))
			: 10'($urandom_range(0, 816));
		if ($urandom_range(0, 9) == 0) begin
			r = 9'($urandom);
			c = 9'($urandom);
		end else begin
			r = 9'($urandom_range(0, hmb - 1));
			c = 9'($urandom_range(0, wmb - 1));
		end
		send_query(f, d, r, c);
	endtask

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				random_query();
				burst--;
				n--;
			end
			if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 30));
		end
	endtask

	logic [13:0] sizes[10][2] = '{
		'{14'd1920, 14'd1080}, '{14'd1, 14'd1}, '{14'd8192, 14'd8192},
		'{14'd16383, 14'd17}, '{14'd0, 14'd0}, '{14'd1280, 14'd720},
		'{14'd352, 14'd288}, '{14'd100, 14'd5000}, '{14'd16, 14'd8192},
		'{14'd8192, 14'd16}
	};

	initial begin
		offsets = new();
		arst_n = 1'b0;
		hold_off = 1'b0;
		req.valid = 1'b0;
		req.roi_fraction = '0;
		req.qp_delta = '0;
		req.mb_row = '0;
		req.mb_col = '0;
		cfg.valid = 1'b0;
		cfg.index = rqm_pkg::REG_FRAME_WIDTH;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, special cases, reset frame size
		send_query(17'd0, 10'd816, 9'd0, 9'd0);            // empty fraction
		send_query(17'd65536, 10'd816, 9'd33, 9'd59);      // whole frame
		send_query(17'h1FFFF, 10'h3FF, 9'd10, 9'd10);      // over range, delta saturates
		send_query(17'd32768, 10'd400, 9'd34, 9'd60);      // centre
		send_query(17'd32768, 10'd400, 9'd0, 9'd0);        // corner, outside roi
		send_query(17'd32768, 10'd1, 9'd68, 9'd0);         // invalid row
		send_query(17'd32768, 10'd1, 9'd0, 9'd120);        // invalid column
		send_query(17'd32768, 10'd1, 9'h1FF, 9'h1FF);      // all row and column bits
		send_query(17'd1, 10'd816, 9'd34, 9'd60);          // roi width rounds to zero
		send_query(17'd65535, 10'd5, 9'd67, 9'd119);       // almost whole frame
		send_query(17'd21000, 10'd77, 9'd40, 9'd70);       // partial last row region
		send_query(17'h0AAAA, 10'h2AA, 9'h0AA, 9'h055);
		send_query(17'h15555, 10'h155, 9'h055, 9'h0AA);

		// pressure: receiver holds off while the sender keeps offering
		fork
			begin
				hold_off <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_off <= 1'b0;
			end
			repeat (8) random_query();
		join
		req.valid <= 1'b0;

		// several frame sizes, extremes among them
		foreach (sizes[k]) begin
			set_frame(sizes[k][0], sizes[k][1]);
			random_phase(190);
		end
		set_frame(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
		random_phase(30);

		drain();
		if (offsets.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
